@@ hw/rtl/tbw_pkg.sv @@
`default_nettype none

package tbw_pkg;

    // grid geometry
    localparam int COLS       = 64;
    localparam int ROWS       = 32;
    localparam int KEEP       = 4;
    localparam int GRID_ROWS  = ROWS + 2;
    localparam int GRID_CELLS = GRID_ROWS * COLS;
    localparam int KEEP_CELLS = (KEEP + 1) * COLS;

    // field and index widths
    localparam int ROW_W  = 6;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int REQ_W  = 2;
    localparam int KIND_W = 2;
    localparam int ADDR_W = $clog2(GRID_CELLS);
    localparam int CNT_W  = $clog2(GRID_CELLS + 1);

    // request codes
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WRAP  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    // redraw codes
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SPAN   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SCREEN = 2'd2;

    // characters of interest
    localparam logic [CHAR_W-1:0] BLANK  = 8'h20;
    localparam logic [CHAR_W-1:0] HYPHEN = 8'h2D;

    // store write port
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [CHAR_W-1:0] data;
    } t_wr_port;

endpackage

`default_nettype wire

@@ hw/rtl/tbw_addr.sv @@
`default_nettype none

// Shared cell address unit: row * COLS + offset
module tbw_addr
    import tbw_pkg::*;
(
    input  wire logic [ROW_W-1:0]  i_row,
    input  wire logic [ADDR_W-1:0] i_off,
    output logic      [ADDR_W-1:0] o_addr
);

    localparam int MUL_W = ADDR_W + ROW_W;

    logic [MUL_W-1:0] w_sum;

    assign w_sum  = MUL_W'(i_row) * MUL_W'(COLS) + MUL_W'(i_off);
    assign o_addr = w_sum[ADDR_W-1:0];

endmodule

`default_nettype wire

@@ hw/rtl/tbw_ram.sv @@
`default_nettype none

// Character store: one write port, one read port with registered data
module tbw_ram
    import tbw_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_wr_port          i_wr,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [CHAR_W-1:0] o_rd_data
);

    logic [CHAR_W-1:0] r_mem [GRID_CELLS];

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/text_buffer_word_wrap_scroll.sv @@
`default_nettype none

// Channel   Dir  tdata (low bit up)                                    tuser
// s_axis    in   cursor_row_in[5:0] cursor_col_in[12:6] char_in[20:13]  req_type[1:0]
// m_axis    out  char_out[7:0] cursor_row_out[13:8] cursor_col_out[20:14]
//                redraw_kind[22:21] redraw_first[28:23] redraw_last[34:29]  -
//
// One word at a time; store reads and most writes go through the shared address unit.
// A wrap scans back for a break and moves the word after it to the next row, and a
// scroll copies (KEEP+1)*COLS cells to the top and blanks the (ROWS+2-KEEP-1)*COLS
// cells after them. After reset the store is cleared to spaces, one cell a cycle,
// with tready low. A result waits in the output register while m_axis stalls.
module text_buffer_word_wrap_scroll
    import tbw_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,   // row, col, char
    input  wire logic [1:0]  i_s_axis_tuser,   // req_type
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [39:0] o_m_axis_tdata    // char, row, col, kind, first, last
);

    typedef enum logic [3:0] {
        ST_CLR, ST_IDLE, ST_RD_CAP, ST_SR_CHK, ST_SR_TST, ST_MV_RD, ST_MV_WD,
        ST_MV_WB, ST_SC_DEC, ST_SC_CP, ST_SC_BL, ST_FIN
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_ovalid;
    logic [39:0]        r_odata;

    logic [ROW_W-1:0]   r_row;
    logic [ROW_W-1:0]   r_nr;
    logic [ROW_W-1:0]   r_shift;
    logic [COL_W-1:0]   r_c;
    logic [COL_W-1:0]   r_b;
    logic [COL_W-1:0]   r_i;
    logic [COL_W-1:0]   r_len;
    logic [COL_W-1:0]   r_ncol;
    logic               r_moved;
    logic [CHAR_W-1:0]  r_char;
    logic [KIND_W-1:0]  r_kind;
    logic [ROW_W-1:0]   r_first;
    logic [ROW_W-1:0]   r_last;

    logic [REQ_W-1:0]   w_req;
    logic [ROW_W-1:0]   w_row;
    logic [COL_W-1:0]   w_col;
    logic [CHAR_W-1:0]  w_char;
    logic               w_acc;
    logic               w_in_grid;
    logic [COL_W-1:0]   w_clamp;
    logic [COL_W-1:0]   w_len;

    logic [ROW_W-1:0]   a_row;
    logic [ADDR_W-1:0]  a_off;
    logic [ADDR_W-1:0]  a_addr;
    logic [ADDR_W-1:0]  w_mv_off;
    t_wr_port           w_wr;
    logic [CHAR_W-1:0]  w_rd_data;

    // input word fields
    assign w_req  = i_s_axis_tuser;
    assign w_row  = i_s_axis_tdata[5:0];
    assign w_col  = i_s_axis_tdata[12:6];
    assign w_char = i_s_axis_tdata[20:13];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_grid       = (w_row < GRID_ROWS) && (w_col < COLS);
    assign w_clamp         = (w_col > COLS) ? COL_W'(COLS) : w_col;
    assign w_len           = r_c - r_b - COL_W'(1);
    assign w_mv_off        = ADDR_W'(r_b) + ADDR_W'(r_i) + ADDR_W'(1);

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    tbw_addr u_addr (
        .i_row  (a_row),
        .i_off  (a_off),
        .o_addr (a_addr)
    );

    tbw_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_addr (a_addr),
        .o_rd_data (w_rd_data)
    );

    // address unit operands and store write port per state
    always_comb begin
        a_row     = r_row;
        a_off     = '0;
        w_wr.we   = 1'b0;
        w_wr.addr = a_addr;
        w_wr.data = BLANK;
        unique case (r_state)
            ST_CLR: begin
                w_wr.we   = 1'b1;
                w_wr.addr = r_cnt[ADDR_W-1:0];
            end
            ST_IDLE: begin
                a_row     = w_row;
                a_off     = ADDR_W'(w_col);
                w_wr.we   = w_acc && (w_req == REQ_WRITE) && w_in_grid;
                w_wr.data = w_char;
            end
            ST_SR_CHK: begin
                a_off = ADDR_W'(r_b);
            end
            ST_MV_RD: begin
                a_off = w_mv_off;
            end
            ST_MV_WD: begin
                a_row     = r_nr;
                a_off     = ADDR_W'(r_i);
                w_wr.we   = 1'b1;
                w_wr.data = w_rd_data;
            end
            ST_MV_WB: begin
                a_off   = w_mv_off;
                w_wr.we = 1'b1;
            end
            ST_SC_CP: begin
                // read ahead at the source, write the cell read last cycle
                a_row     = r_shift;
                a_off     = r_cnt[ADDR_W-1:0];
                w_wr.we   = (r_cnt != '0);
                w_wr.addr = ADDR_W'(r_cnt - CNT_W'(1));
                w_wr.data = w_rd_data;
            end
            ST_SC_BL: begin
                w_wr.we   = 1'b1;
                w_wr.addr = r_cnt[ADDR_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLR;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_m_axis_tready && r_state != ST_FIN) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_CLR: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(GRID_CELLS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_acc) begin
                        r_row   <= w_row;
                        r_nr    <= w_row;
                        r_ncol  <= w_col;
                        r_char  <= '0;
                        r_kind  <= KIND_NONE;
                        r_first <= '0;
                        r_last  <= '0;
                        r_moved <= 1'b0;
                        r_state <= ST_FIN;
                        if (w_req == REQ_READ && w_in_grid) begin
                            r_state <= ST_RD_CAP;
                        end else if (w_req == REQ_WRAP && w_row <= ROWS) begin
                            r_nr    <= w_row + ROW_W'(1);
                            r_ncol  <= '0;
                            r_c     <= w_clamp;
                            r_b     <= w_clamp - COL_W'(1);
                            r_state <= (w_clamp >= COL_W'(2)) ? ST_SR_CHK : ST_SC_DEC;
                        end
                    end
                end
                ST_RD_CAP: begin
                    r_char  <= w_rd_data;
                    r_state <= ST_FIN;
                end
                ST_SR_CHK: begin
                    // column 0 ends the search with no break
                    r_state <= (r_b == '0) ? ST_SC_DEC : ST_SR_TST;
                end
                ST_SR_TST: begin
                    if (w_rd_data == BLANK || w_rd_data == HYPHEN) begin
                        r_moved <= 1'b1;
                        r_len   <= w_len;
                        r_ncol  <= w_len;
                        r_i     <= '0;
                        r_state <= (w_len == '0) ? ST_SC_DEC : ST_MV_RD;
                    end else begin
                        r_b     <= r_b - COL_W'(1);
                        r_state <= ST_SR_CHK;
                    end
                end
                ST_MV_RD: begin
                    r_state <= ST_MV_WD;
                end
                ST_MV_WD: begin
                    r_state <= ST_MV_WB;
                end
                ST_MV_WB: begin
                    r_i     <= r_i + COL_W'(1);
                    r_state <= (r_i + COL_W'(1) == r_len) ? ST_SC_DEC : ST_MV_RD;
                end
                ST_SC_DEC: begin
                    r_cnt   <= '0;
                    r_shift <= r_nr - ROW_W'(KEEP);
                    r_state <= ST_FIN;
                    if (r_nr >= ROWS) begin
                        if (r_nr > KEEP) begin
                            r_state <= ST_SC_CP;
                        end
                    end else if (r_moved) begin
                        r_kind  <= KIND_SPAN;
                        r_first <= r_row;
                        r_last  <= r_nr;
                    end
                end
                ST_SC_CP: begin
                    if (r_cnt == CNT_W'(KEEP_CELLS)) begin
                        r_state <= ST_SC_BL;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                ST_SC_BL: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(GRID_CELLS - 1)) begin
                        r_nr    <= ROW_W'(KEEP);
                        r_kind  <= KIND_SCREEN;
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_odata  <= {5'b0, r_last, r_first, r_kind, r_ncol, r_nr, r_char};
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // a taken word leaves the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> !o_s_axis_tready)
        else $error("tready held high after accepting a word");

    // a scroll leaves the cursor on the kept row
    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[22:21] == KIND_SCREEN)
        |-> (o_m_axis_tdata[13:8] == ROW_W'(KEEP)))
        else $error("screen redraw with cursor off the kept row");

    // a row span covers the old row and the next one
    a_span_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[22:21] == KIND_SPAN)
        |-> (o_m_axis_tdata[34:29] == o_m_axis_tdata[28:23] + ROW_W'(1)))
        else $error("row span is not two adjacent rows");

    // nothing is reported while the store is still being cleared
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLR) |-> (!o_m_axis_tvalid && !o_s_axis_tready))
        else $error("handshake active during store clear");
`endif

endmodule

`default_nettype wire

@@ sim/text_buffer_word_wrap_scroll_tb.sv @@
module text_buffer_word_wrap_scroll_tb;
    import tbw_pkg::*;

    // one queued request word, as the sender will put it on s_axis
    typedef struct {
        logic [REQ_W-1:0]  req;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [CHAR_W-1:0] ch;
        bit                wait_idle;   // hold until every reply is back
    } keystroke_t;

    // one reply word, unpacked
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [KIND_W-1:0] kind;
        logic [ROW_W-1:0]  first;
        logic [ROW_W-1:0]  last;
    } cursor_reply_t;

    localparam int RANDOM_WORDS = 250;
    localparam int LONG_HOLD    = 3000;

    // request code with no meaning; the block passes the cursor through
    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata = '0;   // row[5:0] col[12:6] char[20:13]
    logic [1:0]  i_s_axis_tuser = '0;   // req_type[1:0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;        // char, row, col, kind, first, last

    keystroke_t    keystrokes[$];
    cursor_reply_t expected_replies[$];
    logic [CHAR_W-1:0] screen_mem [GRID_CELLS];

    int  words_queued = 0;
    int  words_sent = 0;
    int  words_taken = 0;
    int  words_out = 0;
    int  mismatch_count = 0;
    bit  s_taken = 1'b0;
    bit  rx_hold = 1'b0;
    keystroke_t    next_word;
    cursor_reply_t got_reply;
    cursor_reply_t want_reply;

    text_buffer_word_wrap_scroll u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // grid model: applies one request and returns the reply it causes
    task automatic edit_screen(input logic [REQ_W-1:0] req, input logic [ROW_W-1:0] row,
                               input logic [COL_W-1:0] col, input logic [CHAR_W-1:0] ch,
                               output cursor_reply_t rep);
        int r, c, b, len, nr, shift, i;
        bit moved;
        rep = '0;
        rep.row = row;
        rep.col = col;
        rep.kind = KIND_NONE;
        if (req == REQ_WRITE || req == REQ_READ) begin
            if (int'(row) < GRID_ROWS && int'(col) < COLS) begin
                if (req == REQ_WRITE)
                    screen_mem[int'(row) * COLS + int'(col)] = ch;
                else
                    rep.ch = screen_mem[int'(row) * COLS + int'(col)];
            end
        end else if (req == REQ_WRAP && int'(row) <= ROWS) begin
            r = int'(row);
            c = (int'(col) > COLS) ? COLS : int'(col);
            nr = r + 1;
            moved = 1'b0;
            rep.col = '0;
            // look back for a break point, then move the trailing word down
            if (c >= 2) begin
                b = c - 1;
                while (b > 0 && screen_mem[r * COLS + b] != BLANK &&
                       screen_mem[r * COLS + b] != HYPHEN)
                    b--;
                if (b > 0) begin
                    len = c - b - 1;
                    for (i = 0; i < len; i++) begin
                        screen_mem[nr * COLS + i] = screen_mem[r * COLS + b + 1 + i];
                        screen_mem[r * COLS + b + 1 + i] = BLANK;
                    end
                    rep.col = COL_W'(len);
                    moved = 1'b1;
                end
            end
            // scroll once the cursor leaves the visible rows
            if (nr >= ROWS) begin
                if (nr > KEEP) begin
                    shift = nr - KEEP;
                    for (i = 0; i < KEEP_CELLS; i++)
                        screen_mem[i] = screen_mem[i + shift * COLS];
                    for (i = KEEP_CELLS; i < GRID_CELLS; i++)
                        screen_mem[i] = BLANK;
                    nr = KEEP;
                    rep.kind = KIND_SCREEN;
                end
            end else if (moved) begin
                rep.kind = KIND_SPAN;
                rep.first = ROW_W'(r);
                rep.last = ROW_W'(nr);
            end
            rep.row = ROW_W'(nr);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("word %0d: %s mismatch, got 0x%0h expected 0x%0h", words_out, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    task automatic push_word(input logic [REQ_W-1:0] req, input int row, input int col,
                             input int ch, input bit wait_idle);
        keystroke_t k;
        k.req = req;
        k.row = ROW_W'(row);
        k.col = COL_W'(col);
        k.ch = CHAR_W'(ch);
        k.wait_idle = wait_idle;
        keystrokes.push_back(k);
        words_queued++;
    endtask

    // types a string along a row, one write per character
    task automatic push_text(input int row, input int col, input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            push_word(REQ_WRITE, row, col + i, s[i], 1'b0);
    endtask

    // mostly letters, some breaks, now and then any byte
    function automatic int pick_char();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return "a" + $urandom_range(0, 25);
        else if (sel < 85)
            return BLANK;
        else if (sel < 95)
            return HYPHEN;
        return $urandom_range(0, 255);
    endfunction

    // idle rates per phase: sender busy-light then heavy, then none
    function automatic int tx_idle_pct();
        if (words_sent < 90)
            return 23;
        else if (words_sent < 180)
            return 74;
        return 0;
    endfunction

    function automatic int rx_idle_pct();
        if (words_sent < 90)
            return 74;
        else if (words_sent < 180)
            return 23;
        return 0;
    endfunction

    // sender: new word on the falling edge once the last one was taken
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_s_axis_tvalid || s_taken) begin
                s_taken = 1'b0;
                if (keystrokes.size() != 0 &&
                    !(keystrokes[0].wait_idle && expected_replies.size() != 0) &&
                    $urandom_range(0, 99) >= tx_idle_pct()) begin
                    next_word = keystrokes.pop_front();
                    i_s_axis_tdata <= {3'b000, next_word.ch, next_word.col, next_word.row};
                    i_s_axis_tuser <= next_word.req;
                    i_s_axis_tvalid <= 1'b1;
                    words_sent++;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        if (!i_rst_n || rx_hold)
            i_m_axis_tready <= 1'b0;
        else
            i_m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct());
    end

    // monitor: check replies, predict on every accepted request
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                words_out++;
                if (expected_replies.size() == 0) begin
                    report_mismatch("unexpected reply", o_m_axis_tdata[31:0], 0);
                end else begin
                    want_reply = expected_replies.pop_front();
                    check_field("char", o_m_axis_tdata[7:0], want_reply.ch);
                    check_field("cursor row", o_m_axis_tdata[13:8], want_reply.row);
                    check_field("cursor col", o_m_axis_tdata[20:14], want_reply.col);
                    check_field("redraw kind", o_m_axis_tdata[22:21], want_reply.kind);
                    check_field("redraw first", o_m_axis_tdata[28:23], want_reply.first);
                    check_field("redraw last", o_m_axis_tdata[34:29], want_reply.last);
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                s_taken = 1'b1;
                words_taken++;
                edit_screen(i_s_axis_tuser, i_s_axis_tdata[5:0], i_s_axis_tdata[12:6],
                            i_s_axis_tdata[20:13], got_reply);
                expected_replies.push_back(got_reply);
            end
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial begin
        wait (words_sent >= 200);
        @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // stimulus and end of run
    initial begin
        int row, col, n, k, sel;
        for (k = 0; k < GRID_CELLS; k++)
            screen_mem[k] = BLANK;

        // cell access at the grid edges and outside it
        push_word(REQ_READ, 0, 0, 0, 1'b0);
        push_word(REQ_WRITE, GRID_ROWS - 1, COLS - 1, 8'hFF, 1'b0);
        push_word(REQ_READ, GRID_ROWS - 1, COLS - 1, 0, 1'b0);
        push_word(REQ_WRITE, GRID_ROWS, 0, 8'h41, 1'b0);
        push_word(REQ_WRITE, 0, COLS, 8'h41, 1'b0);
        push_word(REQ_READ, 63, 127, 0, 1'b0);
        push_word(REQ_READ, 0, COLS, 0, 1'b0);
        push_word(REQ_WRITE, 0, 0, 8'h00, 1'b0);
        push_word(REQ_READ, 0, 0, 0, 1'b0);
        // word moved after a space, then after a hyphen
        push_text(2, 0, "ab cd");
        push_word(REQ_WRAP, 2, 5, 0, 1'b0);
        push_text(5, 0, "x-y");
        push_word(REQ_WRAP, 5, 3, 0, 1'b0);
        // cursor too close to the left edge, then no break in the line
        push_word(REQ_WRAP, 7, 1, 0, 1'b0);
        push_word(REQ_WRAP, 2, 2, 0, 1'b0);
        // column past the row end is clamped
        push_word(REQ_WRAP, 10, 127, 0, 1'b0);
        // wrap on the last hidden row is ignored, as is the unused request
        push_word(REQ_WRAP, GRID_ROWS - 1, 5, 0, 1'b0);
        push_word(REQ_SPARE, 63, 127, 8'hFF, 1'b0);
        // scroll from the last visible row
        push_word(REQ_WRAP, ROWS - 1, 10, 0, 1'b0);

        // random typing: lines of words ending in a wrap, plus loose traffic
        push_word(REQ_READ, 0, 0, 0, 1'b1);
        while (words_queued < 25 + RANDOM_WORDS) begin
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                row = ($urandom_range(0, 3) == 0) ? $urandom_range(28, 32)
                                                  : $urandom_range(0, GRID_ROWS - 1);
                col = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 60)
                                                  : $urandom_range(0, 20);
                n = $urandom_range(2, 14);
                for (k = 0; k < n && col < COLS; k++) begin
                    push_word(REQ_WRITE, row, col, pick_char(), 1'b0);
                    col++;
                end
                if ($urandom_range(0, 4) == 0)
                    push_word(REQ_READ, row, $urandom_range(0, COLS - 1), 0, 1'b0);
                if ($urandom_range(0, 9) == 0)
                    col = $urandom_range(col, 127);
                push_word(REQ_WRAP, row, col, $urandom_range(0, 255), 1'b0);
            end else if (sel < 80) begin
                push_word(REQ_READ, $urandom_range(0, 63), $urandom_range(0, 127),
                          $urandom_range(0, 255), 1'b0);
            end else if (sel < 90) begin
                push_word(REQ_WRITE, $urandom_range(0, 63), $urandom_range(0, 127),
                          $urandom_range(0, 255), 1'b0);
            end else if (sel < 95) begin
                push_word(REQ_WRAP, $urandom_range(0, 63), $urandom_range(0, 127),
                          $urandom_range(0, 255), 1'b0);
            end else begin
                push_word(REQ_SPARE, $urandom_range(0, 63), $urandom_range(0, 127),
                          $urandom_range(0, 255), 1'b0);
            end
            if ($urandom_range(0, 24) == 0)
                push_word(REQ_READ, $urandom_range(0, GRID_ROWS - 1),
                          $urandom_range(0, COLS - 1), 0, 1'b1);
        end

        // reset, then let the queue drain
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (words_taken < words_queued)
            @(posedge i_clk);
        while (expected_replies.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0 && expected_replies.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
